// File: hw/rtl/ple_pkg.sv
// shared types and constants for the positional list engine
package ple_pkg;

  localparam int unsigned DefDepth = 32;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 6;
  localparam int unsigned LenW     = 6;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_COUNT     = 3'd6,
    OP_READ_ALL  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_REMOVE = 2'd2,
    CM_ROTATE = 2'd3
  } cell_mode_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  typedef struct packed {
    cell_mode_e               mode;
    logic signed [DataW-1:0]  value;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/positional_list_engine_core.sv
// top level: request control, result register and the row of list cells
// an accepted update or count shows its result in the cycle after; a read-out enters the read state first
// updates and count: one item per cycle unless stalled, all cells shift together
// read-out of n elements: n results from cell 0 as the chain rotates, one per cycle unless stalled
// a read-out blocks new items until its last result is loaded
// reset clears the fill count and control; cell contents stay unknown until written
module positional_list_engine_core import ple_pkg::*; #(
  parameter int unsigned Depth = DefDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              in_op_i,
  input  logic signed [DataW-1:0] in_value_i,
  input  logic [PosW-1:0]         in_position_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] out_element_o,
  output logic [LenW-1:0]         out_length_o,
  output logic [1:0]              out_status_o,
  output logic                    out_last_o
);

  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam int unsigned CmpW  = (FillW > PosW ? FillW : PosW) + 1;

  op_e                     op;
  logic                    accept, out_free, full, empty;
  logic [CmpW-1:0]         pos_ext, fill_ext;
  logic [PosW-1:0]         pos_m1;
  state_e                  state_d, state_q;
  logic [FillW-1:0]        fill_d, fill_q;
  logic [FillW-1:0]        rd_left_d, rd_left_q;
  logic                    out_valid_d, out_valid_q;
  logic signed [DataW-1:0] element_d, element_q;
  logic [LenW-1:0]         length_d, length_q;
  status_e                 status_d, status_q;
  logic                    last_d, last_q;
  cell_ctrl_t              ctrl;
  logic [IdxW-1:0]         slot, last_idx;
  logic signed [DataW-1:0] cell_data [Depth];

  assign op         = op_e'(in_op_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (fill_q == FillW'(Depth));
  assign empty      = (fill_q == '0);
  assign pos_ext    = CmpW'(in_position_i);
  assign fill_ext   = CmpW'(fill_q);
  assign pos_m1     = in_position_i - PosW'(1);
  assign last_idx   = IdxW'(fill_q - FillW'(1));

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_left_d   = rd_left_q;
    out_valid_d = out_valid_q && out_stall_i;
    element_d   = element_q;
    length_d    = length_q;
    status_d    = status_q;
    last_d      = last_q;
    ctrl.mode   = CM_HOLD;
    ctrl.value  = in_value_i;
    slot        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          unique case (op)
            OP_INS_FRONT, OP_INS_END: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.mode = CM_INSERT;
                slot      = (op == OP_INS_FRONT) ? '0 : IdxW'(fill_q);
                fill_d    = fill_q + FillW'(1);
              end
            end
            OP_INS_POS: begin
              if (pos_ext == '0 || pos_ext > fill_ext + CmpW'(1)) begin
                status_d = ST_BAD_POS;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.mode = CM_INSERT;
                slot      = IdxW'(pos_m1);
                fill_d    = fill_q + FillW'(1);
              end
            end
            OP_DEL_FRONT, OP_DEL_END: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                ctrl.mode = CM_REMOVE;
                slot      = (op == OP_DEL_FRONT) ? '0 : last_idx;
                fill_d    = fill_q - FillW'(1);
              end
            end
            OP_DEL_POS: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (pos_ext == '0 || pos_ext > fill_ext) begin
                status_d = ST_BAD_POS;
              end else begin
                ctrl.mode = CM_REMOVE;
                slot      = IdxW'(pos_m1);
                fill_d    = fill_q - FillW'(1);
              end
            end
            OP_COUNT: status_d = ST_OK;
            OP_READ_ALL: begin
              if (empty) status_d = ST_EMPTY;
            end
          endcase
          if (op == OP_READ_ALL && !empty) begin
            state_d   = S_READ;
            rd_left_d = fill_q;
          end else begin
            out_valid_d = 1'b1;
            element_d   = '0;
            length_d    = LenW'(fill_d);
            last_d      = 1'b1;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          element_d   = cell_data[0];
          length_d    = LenW'(fill_q);
          status_d    = ST_OK;
          last_d      = (rd_left_q == FillW'(1));
          ctrl.mode   = CM_ROTATE;
          rd_left_d   = rd_left_q - FillW'(1);
          if (rd_left_q == FillW'(1)) state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    element_q <= element_d;
    length_q  <= length_d;
    status_q  <= status_d;
    last_q    <= last_d;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_final
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_data[i+1];
    end
    ple_cell #(
      .Depth (Depth),
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .slot_i  (slot),
      .last_i  (last_idx),
      .left_i  (left),
      .right_i (right),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign out_element_o = element_q;
  assign out_length_o  = length_q;
  assign out_status_o  = status_q;
  assign out_last_o    = last_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Depth))
    else $error("fill count above depth");

  a_read_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) ##1 (state_q == S_READ) |-> rd_left_q == fill_q)
    else $error("read-out count does not match fill");

  a_read_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> $stable(fill_q))
    else $error("fill changed during read-out");

  a_read_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> rd_left_q != '0)
    else $error("read-out with nothing left");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ctrl.mode == CM_INSERT |=> fill_q == FillW'($past(fill_q) + FillW'(1)))
    else $error("insert did not grow the list");
`endif

endmodule

// File: hw/rtl/ple_cell.sv
// one storage cell of the list chain, fed by its two neighbours, the head cell and the insert value
module ple_cell import ple_pkg::*; #(
  parameter int unsigned Depth = DefDepth,
  parameter int unsigned Index = 0,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic [IdxW-1:0]         slot_i,
  input  logic [IdxW-1:0]         last_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic signed [DataW-1:0] right_i,
  input  logic signed [DataW-1:0] head_i,
  output logic signed [DataW-1:0] data_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic signed [DataW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.mode)
      CM_HOLD: data_d = data_q;
      CM_INSERT: begin
        if (MyIdx == slot_i) data_d = ctrl_i.value;
        else if (MyIdx > slot_i) data_d = left_i;
      end
      CM_REMOVE: begin
        if (MyIdx >= slot_i) data_d = right_i;
      end
      CM_ROTATE: begin
        // front element wraps round to the tail of the held part
        if (MyIdx == last_i) data_d = head_i;
        else if (MyIdx < last_i) data_d = right_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
